FILE: hw/rtl/pdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_pkg
// Types and codes shared by the door lock sequencer modules.
// ----------------------------------------------------------------------------
package pdl_pkg;

    localparam int ENTRY_W = 40;

    typedef enum logic [1:0] {
        OP_PAIR   = 2'd0,
        OP_OPTION = 2'd1,
        OP_USER   = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_TICK       = 3'd0,
        ST_STORED     = 3'd1,
        ST_MISMATCH   = 3'd2,
        ST_USER_OK    = 3'd3,
        ST_USER_WRONG = 3'd4,
        ST_LOCKOUT    = 3'd5,
        ST_IGNORED    = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        MODE_PAIR   = 4'b0001,
        MODE_OPTION = 4'b0010,
        MODE_USER   = 4'b0100,
        MODE_BUSY   = 4'b1000
    } t_mode;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CW    = 5'b00010,
        PH_HOLD  = 5'b00100,
        PH_CCW   = 5'b01000,
        PH_ALARM = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        AW_PAIR   = 2'd0,
        AW_OPTION = 2'd1,
        AW_USER   = 2'd2,
        AW_BUSY   = 2'd3
    } t_await;

    localparam logic [1:0] MOTOR_OFF = 2'd0;
    localparam logic [1:0] MOTOR_CW  = 2'd1;
    localparam logic [1:0] MOTOR_CCW = 2'd2;

    typedef enum logic [1:0] {
        REG_UNLOCK = 2'd0,
        REG_HOLD   = 2'd1,
        REG_ALARM  = 2'd2,
        REG_MAXF   = 2'd3
    } t_reg_idx;

    localparam logic [7:0] UNLOCK_RST = 8'd30;
    localparam logic [7:0] HOLD_RST   = 8'd6;
    localparam logic [7:0] ALARM_RST  = 8'd120;
    localparam logic [1:0] MAXF_RST   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [ENTRY_W-1:0] entry_a;
        logic [ENTRY_W-1:0] entry_b;
        logic               option;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] motor_drive;
        logic       alarm_on;
        logic [1:0] awaiting;
    } t_out;

    typedef struct packed {
        logic [7:0] unlock_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] alarm_ticks;
        logic [1:0] max_failures;
    } t_cfg;

endpackage

FILE: hw/rtl/pdl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_cfg
// Timing and failure-limit registers with a plain write port.
// ----------------------------------------------------------------------------
module pdl_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_wdata,
    output pdl_pkg::t_cfg     o_cfg
);
    import pdl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_ticks <= UNLOCK_RST;
            r_cfg.hold_ticks   <= HOLD_RST;
            r_cfg.alarm_ticks  <= ALARM_RST;
            r_cfg.max_failures <= MAXF_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_UNLOCK: r_cfg.unlock_ticks <= i_cfg_wdata;
                REG_HOLD:   r_cfg.hold_ticks   <= i_cfg_wdata;
                REG_ALARM:  r_cfg.alarm_ticks  <= i_cfg_wdata;
                REG_MAXF:   r_cfg.max_failures <= i_cfg_wdata[1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/pdl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_seq
// Lock sequencer state and its per-item update, registered when i_fire is high.
// ----------------------------------------------------------------------------
module pdl_seq #(
    parameter int CMP_BITS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  pdl_pkg::t_in      i_item,
    input  pdl_pkg::t_cfg     i_cfg,
    output pdl_pkg::t_out     o_res
);
    import pdl_pkg::*;

    logic [CMP_BITS-1:0] r_stored;
    logic [CMP_BITS-1:0] n_stored;
    t_mode               r_mode,   n_mode;
    logic                r_chosen, n_chosen;
    logic [1:0]          r_fails,  n_fails;
    t_phase              r_phase,  n_phase;
    logic [7:0]          r_timer,  n_timer;

    logic [CMP_BITS-1:0] a_bits;
    logic [CMP_BITS-1:0] b_bits;
    logic [1:0]          fails_inc;
    t_status             status;

    assign a_bits    = i_item.entry_a[CMP_BITS-1:0];
    assign b_bits    = i_item.entry_b[CMP_BITS-1:0];
    assign fails_inc = r_fails + 2'd1;

    always_comb begin
        n_stored = r_stored;
        n_mode   = r_mode;
        n_chosen = r_chosen;
        n_fails  = r_fails;
        n_phase  = r_phase;
        n_timer  = r_timer;
        status   = ST_IGNORED;
        case (t_op'(i_item.op))
            OP_TICK: begin
                status = ST_TICK;
                if (r_mode == MODE_BUSY) begin
                    if (r_timer > 8'd1) begin
                        n_timer = r_timer - 8'd1;
                    end else begin
                        case (r_phase)
                            PH_CW: begin
                                n_phase = PH_HOLD;
                                n_timer = i_cfg.hold_ticks;
                            end
                            PH_HOLD: begin
                                n_phase = PH_CCW;
                                n_timer = i_cfg.unlock_ticks;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_timer = 8'd0;
                                n_mode  = MODE_OPTION;
                            end
                        endcase
                    end
                end
            end
            OP_PAIR: begin
                if (r_mode == MODE_PAIR) begin
                    if (a_bits == b_bits) begin
                        n_stored = a_bits;
                        n_mode   = MODE_OPTION;
                        status   = ST_STORED;
                    end else begin
                        status = ST_MISMATCH;
                    end
                end
            end
            OP_OPTION: begin
                if (r_mode == MODE_OPTION) begin
                    n_chosen = i_item.option;
                    n_mode   = MODE_USER;
                    status   = ST_STORED;
                end
            end
            OP_USER: begin
                if (r_mode == MODE_USER) begin
                    if (a_bits == r_stored) begin
                        n_fails = 2'd0;
                        status  = ST_USER_OK;
                        if (!r_chosen) begin
                            n_phase = PH_CW;
                            n_timer = i_cfg.unlock_ticks;
                            n_mode  = MODE_BUSY;
                        end else begin
                            n_mode = MODE_PAIR;
                        end
                    end else if (fails_inc >= i_cfg.max_failures || fails_inc == 2'd0) begin
                        n_fails = 2'd0;
                        status  = ST_LOCKOUT;
                        n_phase = PH_ALARM;
                        n_timer = i_cfg.alarm_ticks;
                        n_mode  = MODE_BUSY;
                    end else begin
                        n_fails = fails_inc;
                        status  = ST_USER_WRONG;
                    end
                end
            end
            default: status = ST_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PAIR;
            r_chosen <= 1'b0;
            r_fails  <= 2'd0;
            r_phase  <= PH_IDLE;
            r_timer  <= 8'd0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_chosen <= n_chosen;
            r_fails  <= n_fails;
            r_phase  <= n_phase;
            r_timer  <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_stored <= n_stored;
        end
    end

    always_comb begin
        o_res.status      = status;
        o_res.alarm_on    = (n_phase == PH_ALARM);
        case (n_phase)
            PH_CW:   o_res.motor_drive = MOTOR_CW;
            PH_CCW:  o_res.motor_drive = MOTOR_CCW;
            default: o_res.motor_drive = MOTOR_OFF;
        endcase
        case (n_mode)
            MODE_PAIR:   o_res.awaiting = AW_PAIR;
            MODE_OPTION: o_res.awaiting = AW_OPTION;
            MODE_USER:   o_res.awaiting = AW_USER;
            default:     o_res.awaiting = AW_BUSY;
        endcase
    end

endmodule

FILE: hw/rtl/password_door_lock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// password_door_lock_controller
// Door lock sequencer: password setup, option choice, user check, timed
// motor and alarm phases driven by tick items.
// ----------------------------------------------------------------------------
//  channel  | signals                               | transfer when
//  ---------+---------------------------------------+--------------------------
//  input    | i_in_valid, o_in_stall, i_in_data     | valid high, stall low
//  output   | o_out_valid, i_out_stall, o_out_data  | valid high, stall low
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata      | write enable high
//
//  One item per cycle sustained while the output is not stalled; each item
//  passes the input register, then the sequencer update into the result
//  register. Synchronous active-low reset clears control state and loads
//  register defaults. An output stall backs up through the input register to
//  o_in_stall.
// ----------------------------------------------------------------------------
module password_door_lock_controller #(
    parameter int PASS_DIGITS = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pdl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pdl_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_wdata
);
    import pdl_pkg::*;

    localparam int CMP_BITS = (PASS_DIGITS * 8 < ENTRY_W) ? PASS_DIGITS * 8 : ENTRY_W;

    logic  r_in_valid;
    t_in   r_in_data;
    logic  r_out_valid;
    t_out  r_out_data;
    logic  out_free;
    logic  fire;
    t_cfg  cfg;
    t_out  res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    pdl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pdl_seq #(
        .CMP_BITS (CMP_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the door lock sequencer. A short table walks every
// op and mode, covering the failure limit and the alarm phase. Constrained-free
// random sequences then follow a protocol-aware generator across several
// timing settings. Results are checked against the table's expected values or
// an in-bench model of the lock, with random source gaps and sink backpressure.
// ----------------------------------------------------------------------------
module testbench;

    import pdl_pkg::*;

    typedef struct packed {
        t_op                op;
        logic [ENTRY_W-1:0] entry_a;
        logic [ENTRY_W-1:0] entry_b;
        logic               option;
        logic               fixed;
        t_out               want;
    } t_row;

    localparam logic [ENTRY_W-1:0] PW_ZERO = '0;
    localparam logic [ENTRY_W-1:0] PW_ONES = '1;
    localparam logic [ENTRY_W-1:0] PW_MID  = 40'h31_32_33_34_35;
    localparam int N_ROWS = 24;

    // status, motor, buzzer, awaiting
    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{OP_TICK,   PW_ZERO, PW_ZERO, 1'b0, 1'b1, '{ST_TICK,     MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_OPTION, PW_ZERO, PW_ZERO, 1'b1, 1'b1, '{ST_IGNORED,  MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_USER,   PW_ONES, PW_ZERO, 1'b0, 1'b1, '{ST_IGNORED,  MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_PAIR,   PW_ONES, PW_ZERO, 1'b0, 1'b1, '{ST_MISMATCH, MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_PAIR,   PW_ZERO, PW_ONES, 1'b1, 1'b1, '{ST_MISMATCH, MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_PAIR,   40'h80_0000_0000, 40'h00_0000_0001, 1'b0, 1'b1,
            '{ST_MISMATCH, MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_PAIR,   PW_ZERO, PW_ZERO, 1'b0, 1'b1, '{ST_STORED,   MOTOR_OFF, 1'b0, AW_OPTION}},
        '{OP_PAIR,   PW_ONES, PW_ONES, 1'b0, 1'b1, '{ST_IGNORED,  MOTOR_OFF, 1'b0, AW_OPTION}},
        '{OP_USER,   PW_ZERO, PW_ZERO, 1'b0, 1'b1, '{ST_IGNORED,  MOTOR_OFF, 1'b0, AW_OPTION}},
        '{OP_TICK,   PW_ONES, PW_ONES, 1'b1, 1'b1, '{ST_TICK,     MOTOR_OFF, 1'b0, AW_OPTION}},
        '{OP_OPTION, PW_ZERO, PW_ZERO, 1'b1, 1'b1, '{ST_STORED,   MOTOR_OFF, 1'b0, AW_USER}},
        '{OP_USER,   PW_ZERO, PW_ONES, 1'b0, 1'b1, '{ST_USER_OK,  MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_PAIR,   PW_ONES, PW_ONES, 1'b0, 1'b1, '{ST_STORED,   MOTOR_OFF, 1'b0, AW_OPTION}},
        '{OP_OPTION, PW_ZERO, PW_ZERO, 1'b1, 1'b0, '0},
        '{OP_USER,   PW_ZERO, PW_ZERO, 1'b0, 1'b1,
            '{ST_USER_WRONG, MOTOR_OFF, 1'b0, AW_USER}},
        '{OP_USER,   40'hFF_FFFF_FFFE, PW_ZERO, 1'b0, 1'b1,
            '{ST_USER_WRONG, MOTOR_OFF, 1'b0, AW_USER}},
        '{OP_USER,   PW_ONES, PW_ZERO, 1'b0, 1'b1, '{ST_USER_OK,  MOTOR_OFF, 1'b0, AW_PAIR}},
        '{OP_PAIR,   PW_MID,  PW_MID,  1'b0, 1'b0, '0},
        '{OP_OPTION, PW_ZERO, PW_ZERO, 1'b0, 1'b0, '0},
        '{OP_USER,   PW_ONES, PW_ZERO, 1'b0, 1'b1,
            '{ST_USER_WRONG, MOTOR_OFF, 1'b0, AW_USER}},
        '{OP_USER,   PW_ZERO, PW_ZERO, 1'b0, 1'b1,
            '{ST_USER_WRONG, MOTOR_OFF, 1'b0, AW_USER}},
        '{OP_USER,   PW_MID ^ 40'd1, PW_ZERO, 1'b0, 1'b1,
            '{ST_LOCKOUT, MOTOR_OFF, 1'b1, AW_BUSY}},
        '{OP_PAIR,   PW_MID,  PW_MID,  1'b0, 1'b1, '{ST_IGNORED,  MOTOR_OFF, 1'b1, AW_BUSY}},
        '{OP_TICK,   PW_ZERO, PW_ZERO, 1'b0, 1'b1, '{ST_TICK,     MOTOR_OFF, 1'b1, AW_BUSY}}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in        in_data   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_idx   = REG_UNLOCK;
    logic [7:0] cfg_wdata = '0;
    logic       in_stall;
    logic       out_valid;
    t_out       out_data;

    password_door_lock_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lock model state
    t_cfg               lk_cfg    = '{UNLOCK_RST, HOLD_RST, ALARM_RST, MAXF_RST};
    t_await             lk_mode   = AW_PAIR;
    t_phase             lk_phase  = PH_IDLE;
    logic               lk_option = 1'b0;
    logic [1:0]         lk_fails  = 2'd0;
    logic [7:0]         lk_timer  = 8'd0;
    logic [ENTRY_W-1:0] lk_stored = '0;

    t_out lock_results_q [$];
    int   status_tally [7];
    int   bad_results    = 0;
    int   results_seen   = 0;
    int   transfers      = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    function automatic t_out advance_lock(input t_in it);
        t_out    r;
        t_status st;
        st = ST_IGNORED;
        case (t_op'(it.op))
            OP_TICK: begin
                st = ST_TICK;
                if (lk_mode == AW_BUSY) begin
                    if (lk_timer > 8'd1) begin
                        lk_timer = lk_timer - 8'd1;
                    end else begin
                        case (lk_phase)
                            PH_CW: begin
                                lk_phase = PH_HOLD;
                                lk_timer = lk_cfg.hold_ticks;
                            end
                            PH_HOLD: begin
                                lk_phase = PH_CCW;
                                lk_timer = lk_cfg.unlock_ticks;
                            end
                            default: begin
                                lk_phase = PH_IDLE;
                                lk_timer = 8'd0;
                                lk_mode  = AW_OPTION;
                            end
                        endcase
                    end
                end
            end
            OP_PAIR: begin
                if (lk_mode == AW_PAIR) begin
                    if (it.entry_a == it.entry_b) begin
                        lk_stored = it.entry_a;
                        lk_mode   = AW_OPTION;
                        st        = ST_STORED;
                    end else begin
                        st = ST_MISMATCH;
                    end
                end
            end
            OP_OPTION: begin
                if (lk_mode == AW_OPTION) begin
                    lk_option = it.option;
                    lk_mode   = AW_USER;
                    st        = ST_STORED;
                end
            end
            default: begin
                if (lk_mode == AW_USER) begin
                    if (it.entry_a == lk_stored) begin
                        lk_fails = 2'd0;
                        st       = ST_USER_OK;
                        if (lk_option == 1'b0) begin
                            lk_phase = PH_CW;
                            lk_timer = lk_cfg.unlock_ticks;
                            lk_mode  = AW_BUSY;
                        end else begin
                            lk_mode = AW_PAIR;
                        end
                    end else begin
                        lk_fails = lk_fails + 2'd1;
                        st       = ST_USER_WRONG;
                        // 2-bit count wraps to zero past three
                        if (lk_fails >= lk_cfg.max_failures || lk_fails == 2'd0) begin
                            lk_fails = 2'd0;
                            st       = ST_LOCKOUT;
                            lk_phase = PH_ALARM;
                            lk_timer = lk_cfg.alarm_ticks;
                            lk_mode  = AW_BUSY;
                        end
                    end
                end
            end
        endcase
        status_tally[st] = status_tally[st] + 1;
        r.status      = st;
        r.motor_drive = (lk_phase == PH_CW) ? MOTOR_CW :
                        (lk_phase == PH_CCW) ? MOTOR_CCW : MOTOR_OFF;
        r.alarm_on    = (lk_phase == PH_ALARM);
        r.awaiting    = lk_mode;
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] random_code();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(7, 0))
            0:       return PW_ZERO;
            1:       return PW_ONES;
            default: return w[ENTRY_W-1:0];
        endcase
    endfunction

    // mostly legal next steps for the current mode, the rest noise
    function automatic t_in pick_entry();
        t_in it;
        it.op      = 2'($urandom_range(3, 0));
        it.entry_a = random_code();
        it.entry_b = random_code();
        it.option  = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 80) begin
            case (lk_mode)
                AW_PAIR: begin
                    it.op = OP_PAIR;
                    if ($urandom_range(9, 0) < 8) it.entry_b = it.entry_a;
                end
                AW_OPTION: it.op = OP_OPTION;
                AW_USER: begin
                    it.op = OP_USER;
                    if ($urandom_range(9, 0) < 5) it.entry_a = lk_stored;
                end
                default: it.op = OP_TICK;
            endcase
        end
        return it;
    endfunction

    task automatic send_entry(input t_in it, input logic fixed, input t_out want);
        t_out predicted;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = advance_lock(it);
        lock_results_q.push_back(fixed ? want : predicted);
        transfers = transfers + 1;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (lock_results_q.size() != 0);
    endtask

    task automatic program_regs(input t_cfg c);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_UNLOCK;
        cfg_wdata <= c.unlock_ticks;
        @(posedge clk);
        cfg_idx   <= REG_HOLD;
        cfg_wdata <= c.hold_ticks;
        @(posedge clk);
        cfg_idx   <= REG_ALARM;
        cfg_wdata <= c.alarm_ticks;
        @(posedge clk);
        cfg_idx   <= REG_MAXF;
        cfg_wdata <= {6'd0, c.max_failures};
        @(posedge clk);
        cfg_we    <= 1'b0;
        lk_cfg = c;
    endtask

    task automatic run_phase(input logic reprogram, input t_cfg c, input int idle_pct,
                             input int stall_pct, input int target, input int pause_at);
        int done_items;
        done_items = 0;
        if (reprogram) begin
            settle();
            program_regs(c);
        end
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (done_items < target) begin
            if (done_items == pause_at) settle();
            send_entry(pick_entry(), 1'b0, '0);
            done_items = done_items + 1;
        end
    endtask

    task automatic report(input string what);
        bad_results = bad_results + 1;
        if (bad_results <= 10) $display("ERROR result %0d: %s", results_seen, what);
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen = results_seen + 1;
            if (lock_results_q.size() == 0) begin
                report($sformatf("unexpected transfer %p", out_data));
            end else begin
                want = lock_results_q.pop_front();
                if (out_data.status != want.status ||
                    out_data.motor_drive != want.motor_drive ||
                    out_data.alarm_on != want.alarm_on ||
                    out_data.awaiting != want.awaiting) begin
                    report($sformatf({"status %0d/%0d motor %0d/%0d buzzer %0d/%0d ",
                                      "awaiting %0d/%0d (exp/got)"},
                                     want.status, out_data.status,
                                     want.motor_drive, out_data.motor_drive,
                                     want.alarm_on, out_data.alarm_on,
                                     want.awaiting, out_data.awaiting));
                end
            end
        end
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    initial begin
        t_cfg rand_cfg;
        for (int s = 0; s < 7; s++) status_tally[s] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++) begin
            send_entry('{DIR_ROWS[r].op, DIR_ROWS[r].entry_a, DIR_ROWS[r].entry_b,
                         DIR_ROWS[r].option},
                       DIR_ROWS[r].fixed, DIR_ROWS[r].want);
        end

        rand_cfg = '{8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)),
                     8'($urandom_range(8, 1)), 2'($urandom_range(3, 1))};
        // reset timing first, then the lowest, a mixed, the highest and a random small setting
        run_phase(1'b0, lk_cfg, 0, 0, 250, -1);
        run_phase(1'b1, '{8'd1, 8'd1, 8'd1, 2'd1}, 52, 0, 150, -1);
        run_phase(1'b1, '{8'd3, 8'd2, 8'd5, 2'd2}, 0, 52, 150, 75);
        run_phase(1'b1, '{8'd255, 8'd255, 8'd255, 2'd3}, 30, 30, 250, -1);
        run_phase(1'b1, rand_cfg, 0, 0, 100, -1);

        settle();
        repeat (4) @(posedge clk);

        $display("Covered %0d transfers over five timing settings, 1 and 255 included.",
                 transfers);
        $display("Status counts: tick %0d stored %0d unequal %0d ok %0d wrong %0d lock %0d ign %0d",
                 status_tally[ST_TICK], status_tally[ST_STORED], status_tally[ST_MISMATCH],
                 status_tally[ST_USER_OK], status_tally[ST_USER_WRONG],
                 status_tally[ST_LOCKOUT], status_tally[ST_IGNORED]);
        if (bad_results == 0 && lock_results_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", lock_results_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
